[sv/bam_pkg.sv]
package bam_pkg;

	// Field widths fixed by the request and result formats
	localparam int OP_W     = 3;
	localparam int NODE_W   = 6;
	localparam int CNT_W    = 7;
	// Rows held at most: node indices are six bits wide
	localparam int MAX_ROWS = 64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_REM   = 3'd1;
	localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
	localparam logic [OP_W-1:0] OP_RNODE = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST  = 3'd4;

endpackage

[sv/bam_if.sv]
// Request channel: one operation on the graph
interface bam_req_if import bam_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, op, node_a, node_b, input ready);
	modport sink   (input valid, op, node_a, node_b, output ready);
endinterface

// Response channel: one result transaction
interface bam_rsp_if import bam_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              edge_present;
	logic [NODE_W-1:0] neighbour;
	logic              neighbour_found;
	logic              last;
	logic              range_error;

	modport source (output valid, edge_present, neighbour, neighbour_found, last,
		range_error, input ready);
	modport sink   (input valid, edge_present, neighbour, neighbour_found, last,
		range_error, output ready);
endinterface

[sv/bam_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle
module bam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/bit_adjacency_matrix.sv]
// Undirected graph store held as a symmetric bit matrix, one RAM row per node.
// Requests arrive on req (valid/ready); results leave on rsp through an output
// register, so a finished result may wait while the next request is taken.
// node_count is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. One request
// is worked at a time; req.ready is high only when idle. Work per operation:
//   error or unused op, self-loop add : no RAM access
//   add / remove edge                  : read-modify-write of both rows
//   test edge                          : read of row a, bit b taken
//   remove node                        : one row RMW for each row below the bound
//   list neighbours                    : one bit of the row examined per cycle,
//                                        holding on a neighbour while rsp stalls
// The bound is node_count capped at the rows held. The sequencer shares one RAM
// read port and one write port across all operations.
// Reset clears the per-row valid flags at once, so every row reads as zero
// straight after reset with no clearing pass; node_count resets to 0.
// When rsp is stalled, the sequencer holds before loading the next result;
// RAM updates of the current request are never held back by the receiver.
module bit_adjacency_matrix import bam_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	bam_req_if.sink          req,
	bam_rsp_if.source        rsp
);

	localparam int ROWS = (MAX_NODES < MAX_ROWS) ? MAX_NODES : MAX_ROWS;
	localparam int IW   = $clog2(ROWS);
	localparam logic [ROWS-1:0] ONE = ROWS'(1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DECODE = 10'b0000000010,
		S_WR_A   = 10'b0000000100,
		S_WR_B   = 10'b0000001000,
		S_TEST   = 10'b0000010000,
		S_CLR_RD = 10'b0000100000,
		S_CLR_WR = 10'b0001000000,
		S_LOAD   = 10'b0010000000,
		S_SCAN   = 10'b0100000000,
		S_FIN    = 10'b1000000000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  node_count_q;
	logic [OP_W-1:0]   op_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic [CNT_W-1:0]  lim_q, lim_now;
	logic [IW-1:0]     i_q;
	logic [ROWS-1:0]   row_q;
	logic              present_q, err_q;
	logic [ROWS-1:0]   valid_q;
	logic              rvalid_q;

	logic              out_valid_q;
	logic              out_present_q, out_found_q, out_last_q, out_err_q;
	logic [NODE_W-1:0] out_nb_q;

	logic [IW-1:0]     a_idx, b_idx;
	logic [ROWS-1:0]   bit_a, bit_b, bit_i, lowmask, rdat, ram_rdata, ram_wdata;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	logic              ram_we;
	logic              bad, can_load;
	logic              emit, e_present, e_found, e_last, e_err;
	logic [NODE_W-1:0] e_nb;

	bam_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Bound in force and request decode
	assign lim_now  = (node_count_q > CNT_W'(ROWS)) ? CNT_W'(ROWS) : node_count_q;
	assign a_idx    = a_q[IW-1:0];
	assign b_idx    = b_q[IW-1:0];
	assign bit_a    = ONE << a_idx;
	assign bit_b    = ONE << b_idx;
	assign bit_i    = ONE << i_q;
	assign rdat     = rvalid_q ? ram_rdata : '0;
	assign can_load = !out_valid_q || rsp.ready;
	assign bad      = (op_q > OP_LIST) || (CNT_W'(a_q) >= lim_q) ||
		((op_q <= OP_TEST) && (CNT_W'(b_q) >= lim_q));

	// Columns below the bound
	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			lowmask[j] = (CNT_W'(j) < lim_q);
		end
	end

	// Sequencer: RAM port control, result loading, next state
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = a_idx;
		ram_wdata = rdat;
		ram_raddr = a_idx;
		emit      = 1'b0;
		e_present = 1'b0;
		e_nb      = '0;
		e_found   = 1'b0;
		e_last    = 1'b1;
		e_err     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (bad) begin
					state_d = S_FIN;
				end else begin
					unique case (op_q)
						OP_ADD:   state_d = (a_q == b_q) ? S_FIN : S_WR_A;
						OP_REM:   state_d = S_WR_A;
						OP_TEST:  state_d = S_TEST;
						OP_RNODE: state_d = S_CLR_RD;
						OP_LIST:  state_d = S_LOAD;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_WR_A: begin
				ram_we    = 1'b1;
				ram_waddr = a_idx;
				ram_wdata = (op_q == OP_ADD) ? (rdat | bit_b) : (rdat & ~bit_b);
				ram_raddr = b_idx;
				state_d   = S_WR_B;
			end
			S_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_idx;
				ram_wdata = (op_q == OP_ADD) ? (rdat | bit_a) : (rdat & ~bit_a);
				state_d   = S_FIN;
			end
			S_TEST: begin
				state_d = S_FIN;
			end
			S_CLR_RD: begin
				ram_raddr = i_q;
				state_d   = S_CLR_WR;
			end
			S_CLR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = rdat & ~bit_a & ((i_q == a_idx) ? ~lowmask : '1);
				state_d   = (CNT_W'(i_q) == lim_q - CNT_W'(1)) ? S_FIN : S_CLR_RD;
			end
			S_LOAD: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (row_q == '0) begin
					// empty list: a single result with no neighbour
					if (can_load) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (row_q[i_q] && can_load) begin
					emit    = 1'b1;
					e_nb    = NODE_W'(i_q);
					e_found = 1'b1;
					e_last  = ((row_q & ~bit_i) == '0);
					if (e_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FIN: begin
				if (can_load) begin
					emit      = 1'b1;
					e_present = present_q;
					e_err     = err_q;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
			valid_q      <= '0;
			rvalid_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= valid_q[ram_raddr];
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request registers, scan row and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q      <= req.op;
			a_q       <= req.node_a;
			b_q       <= req.node_b;
			lim_q     <= lim_now;
			present_q <= 1'b0;
			err_q     <= 1'b0;
		end
		if (state_q == S_DECODE) begin
			// unused op codes are ignored, never flagged
			err_q <= bad && (op_q <= OP_LIST);
			i_q   <= '0;
		end
		if (state_q == S_TEST) begin
			present_q <= rdat[b_idx];
		end
		if (state_q == S_CLR_WR) begin
			i_q <= i_q + IW'(1);
		end
		if (state_q == S_LOAD) begin
			row_q <= rdat & lowmask;
		end
		if (state_q == S_SCAN && row_q != '0) begin
			if (!row_q[i_q]) begin
				i_q <= i_q + IW'(1);
			end else if (can_load) begin
				row_q <= row_q & ~bit_i;
				i_q   <= i_q + IW'(1);
			end
		end
		if (emit) begin
			out_present_q <= e_present;
			out_nb_q      <= e_nb;
			out_found_q   <= e_found;
			out_last_q    <= e_last;
			out_err_q     <= e_err;
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.edge_present    = out_present_q;
	assign rsp.neighbour       = out_nb_q;
	assign rsp.neighbour_found = out_found_q;
	assign rsp.last            = out_last_q;
	assign rsp.range_error     = out_err_q;

endmodule
